// ===== src/clws_pkg.sv =====
// Types and constants shared by the command-line word splitter.
package clws_pkg;

    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_BS = 8'h5C;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_QUOTE  = 2'd1;
    localparam logic [1:0] ERR_BSLASH = 2'd2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam int OUT_DATA_W = 64;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_SQUOTE = 5'b00010,
        MODE_DQUOTE = 5'b00100,
        MODE_DQ_ESC = 5'b01000,
        MODE_BSLASH = 5'b10000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_ARG_END = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  arg_byte;
        logic [1:0]  error_code;
        logic [15:0] error_pos;
        logic [15:0] arg_count;
        logic [15:0] total_bytes;
        logic        last;
    } t_result;

endpackage

// ===== src/command_line_word_splitter.sv =====
// Top level of the command-line word splitter: lexer state and two-entry result buffer.
//
//  Channel   Dir  tdata (low bit up)                                        tuser  tlast
//  s_axis    in   byte_in[7:0]                                              -      end_of_line
//  m_axis    out  arg_byte, error_code, error_pos, arg_count, total_bytes   kind   last
//
//  One request is taken per cycle while the result buffer is empty or draining; its results
//  are registered and appear in the next cycle. A request giving two results (argument end
//  before done, or an escaped byte with its backslash) holds the input while both results wait.
//  An output stall holds the input as soon as a result is waiting in the buffer.
//  Reset is synchronous and active low; it clears lexer state and the buffer.
module command_line_word_splitter #(
    parameter int POS_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // byte_in[7:0]
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // arg_byte[7:0], error_code[9:8], error_pos[25:10], arg_count[41:26],
    // total_bytes[57:42], zero fill[63:58]
    output logic [clws_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,   // kind[1:0]
    output logic                              m_axis_tlast
);
    import clws_pkg::*;

    t_mode               r_mode, n_mode;
    logic                r_arg_open, n_arg_open;
    logic [POS_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [POS_BITS-1:0] r_quote_start, n_quote_start;
    logic [15:0]         r_arg_total, n_arg_total;
    logic [15:0]         r_byte_total, n_byte_total;
    logic [15:0]         r_cur_len, n_cur_len;

    t_result             r_out0, n_out0, r_out1, n_out1;
    logic [1:0]          r_cnt, n_cnt;

    t_result             w_res0, w_res1;
    logic [1:0]          w_k;
    logic                w_accept, w_pop;
    logic [15:0]         w_arg_total_inc, w_byte_total_close;
    logic [15:0]         w_len_p1, w_len_p2;
    logic [17:0]         w_sum_close;
    logic [16:0]         w_sum_p1, w_sum_p2;
    logic [31:0]         w_qs_ext;
    logic [7:0]          w_b;
    logic                w_space;

    assign w_pop    = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_b     = s_axis_tdata;
    assign w_space = (w_b == 8'd32) || ((w_b >= 8'd9) && (w_b <= 8'd13));

    assign w_arg_total_inc = (r_arg_total == CNT_MAX) ? r_arg_total : r_arg_total + 16'd1;
    assign w_sum_close = 18'(r_byte_total) + 18'(r_cur_len) + 18'd1;
    assign w_byte_total_close = (w_sum_close > 18'(CNT_MAX)) ? CNT_MAX : w_sum_close[15:0];
    assign w_sum_p1 = 17'(r_cur_len) + 17'd1;
    assign w_sum_p2 = 17'(r_cur_len) + 17'd2;
    assign w_len_p1 = w_sum_p1[16] ? CNT_MAX : w_sum_p1[15:0];
    assign w_len_p2 = w_sum_p2[16] ? CNT_MAX : w_sum_p2[15:0];
    assign w_qs_ext = 32'(r_quote_start);

    always_comb begin
        n_mode        = r_mode;
        n_arg_open    = r_arg_open;
        n_byte_pos    = r_byte_pos;
        n_quote_start = r_quote_start;
        n_arg_total   = r_arg_total;
        n_byte_total  = r_byte_total;
        n_cur_len     = r_cur_len;
        w_res0        = '0;
        w_res1        = '0;
        w_k           = 2'd0;

        if (s_axis_tlast) begin
            if (r_mode == MODE_NORMAL) begin
                if (r_arg_open) begin
                    w_res0.kind        = KIND_ARG_END;
                    w_res1.kind        = KIND_DONE;
                    w_res1.arg_count   = w_arg_total_inc;
                    w_res1.total_bytes = w_byte_total_close;
                    w_k                = 2'd2;
                end else begin
                    w_res0.kind        = KIND_DONE;
                    w_res0.arg_count   = r_arg_total;
                    w_res0.total_bytes = r_byte_total;
                    w_k                = 2'd1;
                end
            end else begin
                w_res0.kind       = KIND_ERROR;
                w_res0.error_code = (r_mode == MODE_BSLASH) ? ERR_BSLASH : ERR_QUOTE;
                w_res0.error_pos  = w_qs_ext[15:0];
                w_k               = 2'd1;
            end
            n_mode        = MODE_NORMAL;
            n_arg_open    = 1'b0;
            n_byte_pos    = '0;
            n_quote_start = '0;
            n_arg_total   = '0;
            n_byte_total  = '0;
            n_cur_len     = '0;
        end else begin
            case (r_mode)
                MODE_SQUOTE: begin
                    if (w_b == CH_SQ) begin
                        n_mode = MODE_NORMAL;
                    end else begin
                        w_res0.arg_byte = w_b;
                        w_k             = 2'd1;
                    end
                end
                MODE_DQUOTE: begin
                    if (w_b == CH_DQ) begin
                        n_mode = MODE_NORMAL;
                    end else if (w_b == CH_BS) begin
                        n_mode = MODE_DQ_ESC;
                    end else begin
                        w_res0.arg_byte = w_b;
                        w_k             = 2'd1;
                    end
                end
                MODE_DQ_ESC: begin
                    n_mode = MODE_DQUOTE;
                    if ((w_b != CH_BS) && (w_b != CH_DQ)) begin
                        w_res0.arg_byte = CH_BS;
                        w_res1.arg_byte = w_b;
                        w_k             = 2'd2;
                    end else begin
                        w_res0.arg_byte = w_b;
                        w_k             = 2'd1;
                    end
                end
                MODE_BSLASH: begin
                    n_mode          = MODE_NORMAL;
                    w_res0.arg_byte = w_b;
                    w_k             = 2'd1;
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (w_space) begin
                        if (r_arg_open) begin
                            w_res0.kind  = KIND_ARG_END;
                            w_k          = 2'd1;
                            n_arg_total  = w_arg_total_inc;
                            n_byte_total = w_byte_total_close;
                            n_cur_len    = '0;
                            n_arg_open   = 1'b0;
                        end
                    end else if (w_b == CH_SQ) begin
                        n_quote_start = r_byte_pos;
                        n_mode        = MODE_SQUOTE;
                    end else if (w_b == CH_DQ) begin
                        n_quote_start = r_byte_pos;
                        n_mode        = MODE_DQUOTE;
                    end else if (w_b == CH_BS) begin
                        n_quote_start = r_byte_pos;
                        n_mode        = MODE_BSLASH;
                    end else begin
                        w_res0.arg_byte = w_b;
                        w_k             = 2'd1;
                    end
                end
            endcase
            // advance the open argument for emitted bytes
            if ((w_k != 2'd0) && (w_res0.kind == KIND_BYTE)) begin
                n_arg_open = 1'b1;
                n_cur_len  = (w_k == 2'd2) ? w_len_p2 : w_len_p1;
            end
            if (!(&r_byte_pos)) begin
                n_byte_pos = r_byte_pos + 1'b1;
            end
        end
        w_res0.last = (w_k == 2'd1);
        w_res1.last = 1'b1;
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_out0 = r_out0;
        n_out1 = r_out1;
        if (w_accept && (w_k != 2'd0)) begin
            n_cnt  = w_k;
            n_out0 = w_res0;
            n_out1 = w_res1;
        end else if (w_pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_out0 = r_out1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NORMAL;
            r_arg_open    <= 1'b0;
            r_byte_pos    <= '0;
            r_quote_start <= '0;
            r_arg_total   <= '0;
            r_byte_total  <= '0;
            r_cur_len     <= '0;
            r_cnt         <= 2'd0;
        end else begin
            if (w_accept) begin
                r_mode        <= n_mode;
                r_arg_open    <= n_arg_open;
                r_byte_pos    <= n_byte_pos;
                r_quote_start <= n_quote_start;
                r_arg_total   <= n_arg_total;
                r_byte_total  <= n_byte_total;
                r_cur_len     <= n_cur_len;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out0 <= n_out0;
        r_out1 <= n_out1;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = r_out0.kind;
    assign m_axis_tlast  = r_out0.last;
    assign m_axis_tdata  = {6'd0, r_out0.total_bytes, r_out0.arg_count, r_out0.error_pos,
                            r_out0.error_code, r_out0.arg_byte};

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready)
        else $error("request accepted with a full result buffer");

    a_pair_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_out0.last)
        else $error("first result of a pair marked last");

    a_line_end_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == KIND_DONE) || (m_axis_tuser == KIND_ERROR)))
        |-> m_axis_tlast)
        else $error("done or error result not marked last");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> ((r_byte_pos == '0) && !r_arg_open
                                        && (r_mode == MODE_NORMAL)))
        else $error("lexer state not cleared after line end");

endmodule

// ===== bench/tb_command_line_word_splitter.sv =====
// Self-checking testbench for the command-line word splitter stream block.
`timescale 1ns / 100ps

module tb_command_line_word_splitter;

    import clws_pkg::*;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [7:0] CH_SP = 8'h20;
    localparam int N_RANDOM = 1150;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_line_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        tx_valid = 1'b0;
    logic [7:0]  tx_data = 8'h00;
    logic        tx_last = 1'b0;
    logic        rx_ready = 1'b0;

    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    t_line_req pending_q[$];
    t_result   result_q[$];

    // lexer state of the prediction
    t_mode            tok_mode = MODE_NORMAL;
    logic             in_word = 1'b0;
    logic [POS_W-1:0] line_pos = '0;
    logic [POS_W-1:0] open_pos = '0;
    logic [15:0]      n_words = '0;
    logic [15:0]      word_bytes = '0;
    logic [15:0]      word_len = '0;

    t_line_req cur;
    t_result   want;
    logic      req_taken = 1'b0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        stall_left = 0;
    int        ready_pct = 100;
    int        n_bad = 0;

    command_line_word_splitter #(
        .POS_BITS(POS_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (tx_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (tx_data),
        .s_axis_tlast  (tx_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (rx_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_SQ || c == CH_DQ || c == CH_BS || is_ws(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] space_byte();
        logic [7:0] c;
        c = ($urandom_range(0, 1) == 0) ? CH_SP : 8'($urandom_range(9, 13));
        return c;
    endfunction

    task automatic add_item(input logic [7:0] ch, input logic eol);
        t_line_req r;
        r.ch = ch;
        r.eol = eol;
        pending_q = {pending_q, r};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b0);
    endtask

    task automatic emit_byte(input logic [7:0] ch);
        t_result r;
        in_word = 1'b1;
        if (word_len != CNT_MAX)
            word_len = word_len + 1'b1;
        r = '0;
        r.kind = KIND_BYTE;
        r.arg_byte = ch;
        result_q = {result_q, r};
    endtask

    task automatic close_word();
        int sum;
        t_result r;
        if (in_word) begin
            if (n_words != CNT_MAX)
                n_words = n_words + 1'b1;
            sum = word_bytes + word_len + 1;
            word_bytes = (sum > CNT_MAX) ? CNT_MAX : sum[15:0];
            word_len = '0;
            in_word = 1'b0;
            r = '0;
            r.kind = KIND_ARG_END;
            result_q = {result_q, r};
        end
    endtask

    task automatic tokenize(input logic [7:0] ch, input logic eol);
        int n0;
        t_result r;
        n0 = result_q.size();
        if (eol) begin
            r = '0;
            if (tok_mode == MODE_NORMAL) begin
                close_word();
                r.kind = KIND_DONE;
                r.arg_count = n_words;
                r.total_bytes = word_bytes;
            end else begin
                r.kind = KIND_ERROR;
                r.error_code = (tok_mode == MODE_BSLASH) ? ERR_BSLASH : ERR_QUOTE;
                r.error_pos = open_pos[15:0];
            end
            result_q = {result_q, r};
            tok_mode = MODE_NORMAL;
            in_word = 1'b0;
            line_pos = '0;
            open_pos = '0;
            n_words = '0;
            word_bytes = '0;
            word_len = '0;
        end else begin
            case (tok_mode)
                MODE_SQUOTE: begin
                    if (ch == CH_SQ)
                        tok_mode = MODE_NORMAL;
                    else
                        emit_byte(ch);
                end
                MODE_DQUOTE: begin
                    if (ch == CH_DQ)
                        tok_mode = MODE_NORMAL;
                    else if (ch == CH_BS)
                        tok_mode = MODE_DQ_ESC;
                    else
                        emit_byte(ch);
                end
                MODE_DQ_ESC: begin
                    if (ch != CH_BS && ch != CH_DQ)
                        emit_byte(CH_BS);
                    emit_byte(ch);
                    tok_mode = MODE_DQUOTE;
                end
                MODE_BSLASH: begin
                    emit_byte(ch);
                    tok_mode = MODE_NORMAL;
                end
                default: begin
                    tok_mode = MODE_NORMAL;
                    if (is_ws(ch)) begin
                        close_word();
                    end else if (ch == CH_SQ) begin
                        open_pos = line_pos;
                        tok_mode = MODE_SQUOTE;
                    end else if (ch == CH_DQ) begin
                        open_pos = line_pos;
                        tok_mode = MODE_DQUOTE;
                    end else if (ch == CH_BS) begin
                        open_pos = line_pos;
                        tok_mode = MODE_BSLASH;
                    end else begin
                        emit_byte(ch);
                    end
                end
            endcase
            if (line_pos != POS_MAX)
                line_pos = line_pos + 1'b1;
        end
        if (result_q.size() > n0) begin
            r = result_q.pop_back();
            r.last = 1'b1;
            result_q = {result_q, r};
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sender: bursts of requests with gaps between them
    always @(negedge i_clk) begin
        if (i_rst_n && !(tx_valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                tx_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                tx_valid <= 1'b1;
                tx_data <= cur.ch;
                tx_last <= cur.eol;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                tx_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // receiver: stretches of differing readiness
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(10, 200);
            ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 95);
        end else begin
            stall_left = stall_left - 1;
        end
        rx_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tx_valid && s_axis_tready) begin
                req_taken = 1'b1;
                tokenize(tx_data, tx_last);
            end
            if (m_axis_tvalid && rx_ready) begin
                if (result_q.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("%0t: unexpected result kind=%0d tdata=%h last=%0b",
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tlast !== want.last ||
                        m_axis_tdata[7:0] !== want.arg_byte ||
                        m_axis_tdata[9:8] !== want.error_code ||
                        m_axis_tdata[25:10] !== want.error_pos ||
                        m_axis_tdata[41:26] !== want.arg_count ||
                        m_axis_tdata[57:42] !== want.total_bytes ||
                        m_axis_tdata[63:58] !== 6'd0) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10)
                            $display({"%0t: want kind=%0d byte=%h ec=%0d pos=%0d cnt=%0d ",
                                      "tot=%0d last=%0b, got kind=%0d tdata=%h last=%0b"},
                                     $time, want.kind, want.arg_byte, want.error_code,
                                     want.error_pos, want.arg_count, want.total_bytes,
                                     want.last, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    initial begin
        int n_base;
        logic [7:0] c;

        // quoting, escapes inside double quotes, line end with an open argument
        add_text("a 'b c' \"\\\"\\q\"");
        add_item(8'h00, 1'b1);
        // empty quotes, then trailing backslash
        add_text("''\\");
        add_item(8'hFF, 1'b1);
        // zero and high bytes, whitespace, unterminated quote
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h0B, 1'b0);
        add_item(8'h0D, 1'b0);
        add_item(CH_DQ, 1'b0);
        add_item(8'h5A, 1'b1);

        n_base = pending_q.size();
        while (pending_q.size() - n_base < N_RANDOM) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 20))
                    add_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(0, 12)) begin
                    case ($urandom_range(0, 6))
                        0, 1: begin
                            repeat ($urandom_range(1, 5))
                                add_item(plain_byte(), 1'b0);
                        end
                        2: add_item(space_byte(), 1'b0);
                        3: begin
                            add_item(CH_SQ, 1'b0);
                            repeat ($urandom_range(0, 4)) begin
                                c = 8'($urandom_range(0, 255));
                                add_item((c == CH_SQ) ? CH_DQ : c, 1'b0);
                            end
                            add_item(CH_SQ, 1'b0);
                        end
                        4: begin
                            add_item(CH_DQ, 1'b0);
                            repeat ($urandom_range(0, 4)) begin
                                if ($urandom_range(0, 2) == 0) begin
                                    add_item(CH_BS, 1'b0);
                                    case ($urandom_range(0, 3))
                                        0: add_item(CH_BS, 1'b0);
                                        1: add_item(CH_DQ, 1'b0);
                                        default: add_item(8'($urandom_range(0, 255)), 1'b0);
                                    endcase
                                end else begin
                                    c = 8'($urandom_range(0, 255));
                                    add_item((c == CH_DQ || c == CH_BS) ? CH_SQ : c, 1'b0);
                                end
                            end
                            add_item(CH_DQ, 1'b0);
                        end
                        5: begin
                            add_item(CH_BS, 1'b0);
                            add_item(8'($urandom_range(0, 255)), 1'b0);
                        end
                        default: begin
                            c = ($urandom_range(0, 1) == 0) ? CH_SQ : CH_DQ;
                            add_item(c, 1'b0);
                            add_item(c, 1'b0);
                        end
                    endcase
                end
                // leave the line broken now and then
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: add_item(CH_SQ, 1'b0);
                        1: add_item(CH_DQ, 1'b0);
                        2: begin
                            add_item(CH_DQ, 1'b0);
                            add_item(plain_byte(), 1'b0);
                            add_item(CH_BS, 1'b0);
                        end
                        default: add_item(CH_BS, 1'b0);
                    endcase
                end
            end
            add_item(8'($urandom_range(0, 255)), 1'b1);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_q.size() != 0 || tx_valid)
            @(posedge i_clk);
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_bad == 0)
            $display("tb_command_line_word_splitter OK");
        else
            $display("tb_command_line_word_splitter NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_command_line_word_splitter NOT OK");
        $finish;
    end

endmodule
